// ===== src/hnvp_pkg.sv =====
// Package for the HTTP name/value parser: item types, phase codes, error codes, characters.
`default_nettype none

package hnvp_pkg;

	// One input item: a byte of the parameter text and the end-of-string flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} src_item_t;

	// One result item, produced on the last byte of a string.
	typedef struct packed {
		logic        valid_res;
		logic [2:0]  error_code;
		logic [11:0] name_start;
		logic [12:0] name_len;
		logic [12:0] value_start;
		logic [12:0] value_len;
		logic        value_quoted;
	} res_item_t;

	// Parse phases.
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NAME,
		PH_NAME_WS,
		PH_VAL_LEAD,
		PH_PLAIN,
		PH_QUOTE,
		PH_ESC,
		PH_QCLOSED
	} phase_t;

	// Error codes reported in error_code.
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_NO_NAME = 3'd1;
	localparam logic [2:0] ERR_NAME    = 3'd2;
	localparam logic [2:0] ERR_PLAIN   = 3'd3;
	localparam logic [2:0] ERR_QUOTED  = 3'd4;
	localparam logic [2:0] ERR_LONG    = 3'd5;

	// Characters with a special meaning in the grammar.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

endpackage

`default_nettype wire

// ===== src/http_name_value_parser.sv =====
// HTTP name[=value] parameter parser: one byte per item, one result per string.
// res_valid rises when the last byte of a string moves from the input register into the
// result register.
// Throughput: one byte per cycle; the byte class check and state update sit between the
// input register and the state/result registers. A result waiting on res_ready holds back
// a following last byte, and the bytes behind it, until the result is taken.
// Reset: arst_n clears all parse state to the leading-blank phase and empties both registers.
`default_nettype none

module http_name_value_parser #(
	parameter int MAX_LEN = 4096
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 src_valid,
	output logic                src_ready,
	input  hnvp_pkg::src_item_t src_item,
	output logic                res_valid,
	input  wire                 res_ready,
	output hnvp_pkg::res_item_t res_item
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int CW = (PW > 13) ? PW : 13;
	localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LEN);

	// Token characters: letters, digits and the listed punctuation.
	function automatic logic is_token(input logic [7:0] c);
		logic r;
		r = 1'b0;
		if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h61 && c <= 8'h7A)) begin
			r = 1'b1;
		end
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	// Input register.
	logic                s1_valid_s1;
	hnvp_pkg::src_item_t s1_item_s1;
	logic                s1_adv;

	// Parse state.
	hnvp_pkg::phase_t phase_q, nxt_phase;
	logic [CW-1:0]    position_q, nxt_position;
	logic [CW-1:0]    name_begin_q, nxt_name_begin;
	logic [CW-1:0]    name_count_q, nxt_name_count;
	logic [CW-1:0]    value_begin_q, nxt_value_begin;
	logic [CW-1:0]    value_count_q, nxt_value_count;
	logic [CW-1:0]    pending_q, nxt_pending;
	logic             quoted_q, nxt_quoted;
	logic [2:0]       first_err_q, nxt_err;

	// Result register.
	logic                res_valid_q;
	hnvp_pkg::res_item_t res_item_q;
	hnvp_pkg::res_item_t res_comb;

	logic [7:0] c;
	logic       blank;
	logic       plain_bad;
	logic [2:0] fin_err;
	logic       has_value;

	// The input register moves on unless it holds a last byte and the result is blocked.
	assign s1_adv    = !s1_item_s1.last || !res_valid_q || res_ready;
	assign src_ready = !s1_valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (src_ready) begin
			s1_valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			s1_item_s1 <= src_item;
		end
	end

	// Byte classes.
	assign c         = s1_item_s1.data_byte;
	assign blank     = (c == hnvp_pkg::CH_SPACE) || (c == hnvp_pkg::CH_TAB);
	assign plain_bad = (c == hnvp_pkg::CH_CR) || (c == hnvp_pkg::CH_LF) ||
		(c == hnvp_pkg::CH_NUL);

	// Next parse state for the byte in the input register.
	always_comb begin
		nxt_phase       = phase_q;
		nxt_position    = position_q;
		nxt_name_begin  = name_begin_q;
		nxt_name_count  = name_count_q;
		nxt_value_begin = value_begin_q;
		nxt_value_count = value_count_q;
		nxt_pending     = pending_q;
		nxt_quoted      = quoted_q;
		nxt_err         = first_err_q;
		if (position_q >= MAX_LEN_C) begin
			nxt_err = hnvp_pkg::ERR_LONG;
		end else begin
			nxt_position = position_q + CW'(1);
			if (first_err_q == hnvp_pkg::ERR_NONE) begin
				unique case (phase_q)
					hnvp_pkg::PH_LEAD: begin
						if (blank) begin
						end else if (c == hnvp_pkg::CH_EQUAL) begin
							nxt_err = hnvp_pkg::ERR_NO_NAME;
						end else if (is_token(c)) begin
							nxt_name_begin = position_q;
							nxt_name_count = CW'(1);
							nxt_phase      = hnvp_pkg::PH_NAME;
						end else begin
							nxt_err = hnvp_pkg::ERR_NAME;
						end
					end
					hnvp_pkg::PH_NAME: begin
						if (is_token(c)) begin
							nxt_name_count = name_count_q + CW'(1);
						end else if (blank) begin
							nxt_phase = hnvp_pkg::PH_NAME_WS;
						end else if (c == hnvp_pkg::CH_EQUAL) begin
							nxt_phase = hnvp_pkg::PH_VAL_LEAD;
						end else begin
							nxt_err = hnvp_pkg::ERR_NAME;
						end
					end
					hnvp_pkg::PH_NAME_WS: begin
						if (blank) begin
						end else if (c == hnvp_pkg::CH_EQUAL) begin
							nxt_phase = hnvp_pkg::PH_VAL_LEAD;
						end else begin
							nxt_err = hnvp_pkg::ERR_NAME;
						end
					end
					hnvp_pkg::PH_VAL_LEAD: begin
						if (!blank) begin
							nxt_value_begin = position_q;
							nxt_value_count = CW'(1);
							nxt_pending     = '0;
							if (c == hnvp_pkg::CH_QUOTE) begin
								nxt_quoted = 1'b1;
								nxt_phase  = hnvp_pkg::PH_QUOTE;
							end else if (plain_bad) begin
								nxt_err = hnvp_pkg::ERR_PLAIN;
							end else begin
								nxt_phase = hnvp_pkg::PH_PLAIN;
							end
						end
					end
					hnvp_pkg::PH_PLAIN: begin
						if (blank) begin
							nxt_pending = pending_q + CW'(1);
						end else if (plain_bad) begin
							nxt_err = hnvp_pkg::ERR_PLAIN;
						end else begin
							nxt_value_count = value_count_q + pending_q + CW'(1);
							nxt_pending     = '0;
						end
					end
					hnvp_pkg::PH_QUOTE: begin
						nxt_value_count = value_count_q + CW'(1);
						if (c == hnvp_pkg::CH_BSLASH) begin
							nxt_phase = hnvp_pkg::PH_ESC;
						end else if (c == hnvp_pkg::CH_QUOTE) begin
							nxt_phase = hnvp_pkg::PH_QCLOSED;
						end
					end
					hnvp_pkg::PH_ESC: begin
						nxt_value_count = value_count_q + CW'(1);
						nxt_phase       = hnvp_pkg::PH_QUOTE;
					end
					hnvp_pkg::PH_QCLOSED: begin
						if (!blank) begin
							nxt_err = hnvp_pkg::ERR_QUOTED;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Final outcome of a string ending on this byte.
	always_comb begin
		fin_err = nxt_err;
		if (nxt_err == hnvp_pkg::ERR_NONE) begin
			if (nxt_phase == hnvp_pkg::PH_LEAD) begin
				fin_err = hnvp_pkg::ERR_NO_NAME;
			end else if (nxt_phase == hnvp_pkg::PH_QUOTE || nxt_phase == hnvp_pkg::PH_ESC) begin
				fin_err = hnvp_pkg::ERR_QUOTED;
			end
		end
		has_value = (nxt_phase == hnvp_pkg::PH_PLAIN) || (nxt_phase == hnvp_pkg::PH_QCLOSED);
		res_comb            = '0;
		res_comb.error_code = fin_err;
		if (fin_err == hnvp_pkg::ERR_NONE) begin
			res_comb.valid_res  = 1'b1;
			res_comb.name_start = nxt_name_begin[11:0];
			res_comb.name_len   = nxt_name_count[12:0];
			if (has_value) begin
				res_comb.value_start  = nxt_value_begin[12:0];
				res_comb.value_len    = nxt_value_count[12:0];
				res_comb.value_quoted = nxt_quoted;
			end
		end
	end

	// Parse state registers; a last byte returns them to the reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hnvp_pkg::PH_LEAD;
			position_q    <= '0;
			name_begin_q  <= '0;
			name_count_q  <= '0;
			value_begin_q <= '0;
			value_count_q <= '0;
			pending_q     <= '0;
			quoted_q      <= 1'b0;
			first_err_q   <= hnvp_pkg::ERR_NONE;
		end else if (s1_valid_s1 && s1_adv) begin
			if (s1_item_s1.last) begin
				phase_q       <= hnvp_pkg::PH_LEAD;
				position_q    <= '0;
				name_begin_q  <= '0;
				name_count_q  <= '0;
				value_begin_q <= '0;
				value_count_q <= '0;
				pending_q     <= '0;
				quoted_q      <= 1'b0;
				first_err_q   <= hnvp_pkg::ERR_NONE;
			end else begin
				phase_q       <= nxt_phase;
				position_q    <= nxt_position;
				name_begin_q  <= nxt_name_begin;
				name_count_q  <= nxt_name_count;
				value_begin_q <= nxt_value_begin;
				value_count_q <= nxt_value_count;
				pending_q     <= nxt_pending;
				quoted_q      <= nxt_quoted;
				first_err_q   <= nxt_err;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_valid_s1 && s1_adv && s1_item_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && s1_adv && s1_item_s1.last) begin
			res_item_q <= res_comb;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the HTTP name[=value] parser: directed, length, backpressure, random traffic.
`timescale 1ns / 1ps

module tb;
	import hnvp_pkg::*;

	localparam int STR_LIMIT = 4096;
	localparam int HOLD_CYCLES = 300;
	localparam int RUN_LIMIT_NS = 8_000_000;

	typedef logic [7:0] text_t[$];

	logic clk = 1'b0;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	src_item_t src_item;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res_item;

	// Parser state as the testbench tracks it.
	phase_t cur_phase;
	int byte_pos;
	int name_at;
	int name_chars;
	int value_at;
	int value_chars;
	int held_blanks;
	logic value_is_quoted;
	logic [2:0] first_fault;

	res_item_t expected_results[$];
	int fail_count = 0;
	int strings_sent = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	int src_idle_pct = 0;
	int rcv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_active = 1'b0;

	http_name_value_parser #(.MAX_LEN(STR_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item)
	);

	// Free-running clock.
	always #4 clk = ~clk;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	// Letters, digits and the punctuation that HTTP allows in a token.
	function automatic logic is_token_char(input logic [7:0] c);
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
			default: return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h61 && c <= 8'h7A);
		endcase
	endfunction

	function automatic logic is_plain_bad(input logic [7:0] c);
		return c == CH_CR || c == CH_LF || c == CH_NUL;
	endfunction

	// Only the first fault in byte order is kept.
	function automatic void note_fault(input logic [2:0] e);
		if (first_fault == ERR_NONE) begin
			first_fault = e;
		end
	endfunction

	function automatic void clear_parse();
		cur_phase = PH_LEAD;
		byte_pos = 0;
		name_at = 0;
		name_chars = 0;
		value_at = 0;
		value_chars = 0;
		held_blanks = 0;
		value_is_quoted = 1'b0;
		first_fault = ERR_NONE;
	endfunction

	// Advances the tracked parse by one byte and queues the outcome on the last byte.
	function automatic void track_byte(input logic [7:0] c, input logic fin);
		res_item_t r;
		logic [2:0] err;
		if (byte_pos >= STR_LIMIT) begin
			first_fault = ERR_LONG;
		end else begin
			if (first_fault == ERR_NONE) begin
				case (cur_phase)
					PH_LEAD: begin
						if (c == CH_EQUAL) begin
							note_fault(ERR_NO_NAME);
						end else if (is_token_char(c)) begin
							name_at = byte_pos;
							name_chars = 1;
							cur_phase = PH_NAME;
						end else if (!is_blank(c)) begin
							note_fault(ERR_NAME);
						end
					end
					PH_NAME: begin
						if (is_token_char(c)) begin
							name_chars++;
						end else if (is_blank(c)) begin
							cur_phase = PH_NAME_WS;
						end else if (c == CH_EQUAL) begin
							cur_phase = PH_VAL_LEAD;
						end else begin
							note_fault(ERR_NAME);
						end
					end
					PH_NAME_WS: begin
						if (c == CH_EQUAL) begin
							cur_phase = PH_VAL_LEAD;
						end else if (!is_blank(c)) begin
							note_fault(ERR_NAME);
						end
					end
					PH_VAL_LEAD: begin
						if (!is_blank(c)) begin
							value_at = byte_pos;
							value_chars = 1;
							held_blanks = 0;
							if (c == CH_QUOTE) begin
								value_is_quoted = 1'b1;
								cur_phase = PH_QUOTE;
							end else if (is_plain_bad(c)) begin
								note_fault(ERR_PLAIN);
							end else begin
								cur_phase = PH_PLAIN;
							end
						end
					end
					PH_PLAIN: begin
						// Blanks count only once a later non-blank byte follows them.
						if (is_blank(c)) begin
							held_blanks++;
						end else if (is_plain_bad(c)) begin
							note_fault(ERR_PLAIN);
						end else begin
							value_chars += held_blanks + 1;
							held_blanks = 0;
						end
					end
					PH_QUOTE: begin
						value_chars++;
						if (c == CH_BSLASH) begin
							cur_phase = PH_ESC;
						end else if (c == CH_QUOTE) begin
							cur_phase = PH_QCLOSED;
						end
					end
					PH_ESC: begin
						value_chars++;
						cur_phase = PH_QUOTE;
					end
					default: begin
						if (!is_blank(c)) begin
							note_fault(ERR_QUOTED);
						end
					end
				endcase
			end
			byte_pos++;
		end

		if (fin) begin
			err = first_fault;
			if (err == ERR_NONE) begin
				if (cur_phase == PH_LEAD) begin
					err = ERR_NO_NAME;
				end else if (cur_phase == PH_QUOTE || cur_phase == PH_ESC) begin
					err = ERR_QUOTED;
				end
			end
			r = '0;
			r.error_code = err;
			if (err == ERR_NONE) begin
				r.valid_res = 1'b1;
				r.name_start = 12'(name_at);
				r.name_len = 13'(name_chars);
				if (cur_phase == PH_PLAIN || cur_phase == PH_QCLOSED) begin
					r.value_start = 13'(value_at);
					r.value_len = 13'(value_chars);
					r.value_quoted = value_is_quoted;
				end
			end
			expected_results.push_back(r);
			clear_parse();
		end
	endfunction

	// Random byte generators for the different parts of a parameter.
	function automatic logic [7:0] blank_char();
		return $urandom_range(1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] token_char();
		logic [7:0] c;
		do c = 8'($urandom); while (!is_token_char(c));
		return c;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom); while (is_plain_bad(c));
		return c;
	endfunction

	function automatic logic [7:0] quoted_char();
		logic [7:0] c;
		do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic text_t to_text(input string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		return t;
	endfunction

	// Mostly well-formed parameters with random content, some damaged, some pure noise.
	function automatic text_t make_param();
		text_t t;
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 10)) t.push_back(8'($urandom));
			return t;
		end
		repeat ($urandom_range(0, 2)) t.push_back(blank_char());
		repeat ($urandom_range(1, 10)) t.push_back(token_char());
		repeat ($urandom_range(0, 1)) t.push_back(blank_char());
		if ($urandom_range(3) != 0) begin
			t.push_back(CH_EQUAL);
			repeat ($urandom_range(0, 2)) t.push_back(blank_char());
			if ($urandom_range(1)) begin
				t.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(4) == 0) begin
						t.push_back(CH_BSLASH);
						t.push_back(8'($urandom));
					end else begin
						t.push_back(quoted_char());
					end
				end
				t.push_back(CH_QUOTE);
			end else begin
				repeat ($urandom_range(0, 10)) t.push_back(plain_char());
			end
			repeat ($urandom_range(0, 2)) t.push_back(blank_char());
		end
		// Damage one byte, and sometimes cut the string right after it.
		if (kind >= 70) begin
			n = $urandom_range(t.size() - 1);
			case ($urandom_range(5))
				0: t[n] = CH_CR;
				1: t[n] = CH_QUOTE;
				2: t[n] = CH_EQUAL;
				3: t[n] = CH_BSLASH;
				4: t[n] = CH_NUL;
				default: t[n] = 8'($urandom);
			endcase
			if ($urandom_range(2) == 0) begin
				t = t[0:n];
			end
		end
		return t;
	endfunction

	// Offers one byte, with random gaps first; called and returns at a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			src_item <= src_item_t'(9'($urandom));
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= '{data_byte: b, last: fin};
		do @(posedge clk); while (!src_ready);
		track_byte(b, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input text_t t);
		for (int i = 0; i < t.size(); i++) begin
			send_byte(t[i], i == t.size() - 1);
		end
		strings_sent++;
	endtask

	// Result side: random stalls, or a forced hold-off while one is active.
	always @(negedge clk) begin
		res_ready <= !hold_active && ($urandom_range(99) >= rcv_stall_pct);
	end

	// Long hold-off on the result side, timed in cycles.
	initial begin
		forever begin
			@(posedge hold_req);
			@(posedge clk);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	function automatic void check_field(input string label, input logic [12:0] want_v,
		input logic [12:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$display("%0t ns: %s expected %0d, got %0d", $time, label, want_v, got_v);
		end
	endfunction

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				$display("%0t ns: result with nothing expected, got %p", $time, res_item);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("valid_res", 13'(want.valid_res), 13'(res_item.valid_res));
				check_field("error_code", 13'(want.error_code), 13'(res_item.error_code));
				check_field("name_start", 13'(want.name_start), 13'(res_item.name_start));
				check_field("name_len", want.name_len, res_item.name_len);
				check_field("value_start", want.value_start, res_item.value_start);
				check_field("value_len", want.value_len, res_item.value_len);
				check_field("value_quoted", 13'(want.value_quoted), 13'(res_item.value_quoted));
			end
		end
	end

	task automatic test_name_value_forms();
		text_t t;
		send_text(to_text("a"));
		send_text(to_text(" \tname = value \t"));
		send_text(to_text("k="));
		send_text(to_text("k= \t"));
		send_text(to_text("k=a b  c "));
		send_text(to_text("k=="));
		send_text(to_text("!#$%&'*+-.^_|~09AZaz=v"));
		// High byte values are fine in a plain value.
		t = to_text("k=");
		t.push_back(8'hFF);
		send_text(t);
	endtask

	task automatic test_error_cases();
		text_t t;
		send_text(to_text("=x"));
		send_text(to_text("   "));
		send_text(to_text("a b=c"));
		send_text(to_text("@a"));
		t = to_text("a");
		t.push_back(8'hFF);
		send_text(t);
		t = to_text("k=v");
		t.push_back(CH_CR);
		send_text(t);
		t = to_text("k=");
		t.push_back(CH_LF);
		send_text(t);
		t = to_text("k=a");
		t.push_back(CH_NUL);
		send_text(t);
		// Name fault comes before the bad value byte, so it wins.
		t = to_text("a b@=");
		t.push_back(CH_CR);
		send_text(t);
	endtask

	task automatic test_quoted_values();
		send_text(to_text("k=\"a\\\"b\"  "));
		send_text(to_text("k=\"\""));
		send_text(to_text("k = \t\"x y\" \t"));
		send_text(to_text("k=\"abc"));
		send_text(to_text("k=\"ab\\"));
		send_text(to_text("k=\"a\"x"));
		send_text(to_text("k=\"a\"\""));
	endtask

	task automatic test_length_limit();
		text_t t;
		// Longest legal name.
		repeat (STR_LIMIT) t.push_back(token_char());
		send_text(t);
		// Name at the highest offset.
		t = {};
		repeat (STR_LIMIT - 1) t.push_back(blank_char());
		t.push_back(token_char());
		send_text(t);
		// Name and plain value filling the limit exactly, then one byte over it.
		t = {};
		t.push_back(blank_char());
		repeat (2000) t.push_back(token_char());
		t.push_back(CH_EQUAL);
		while (t.size() < STR_LIMIT) t.push_back(plain_char());
		send_text(t);
		t.push_back(token_char());
		send_text(t);
		// An early fault does not hide the length error.
		t = to_text("@");
		repeat (STR_LIMIT + 300) t.push_back(8'($urandom));
		send_text(t);
	endtask

	// Results are held back long enough that the parser stops taking bytes.
	task automatic test_result_backpressure();
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_req = 1'b1;
		repeat (40) send_text(make_param());
		hold_req = 1'b0;
	endtask

	task automatic test_random_traffic(input int send_pct, input int stall_pct,
		input int byte_budget);
		int start_bytes;
		src_idle_pct = send_pct;
		rcv_stall_pct = stall_pct;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < byte_budget) begin
			send_text(make_param());
		end
	endtask

	// Test sequence.
	initial begin
		int drain_wait;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		clear_parse();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_name_value_forms();
		test_error_cases();
		test_quoted_values();
		test_length_limit();
		test_result_backpressure();
		test_random_traffic(0, 0, 375);
		test_random_traffic(88, 0, 375);
		test_random_traffic(0, 88, 375);
		test_random_traffic(34, 34, 375);
		src_valid <= 1'b0;
		rcv_stall_pct = 0;

		// Let the last results drain, then watch for strays.
		drain_wait = 0;
		while (expected_results.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (6) @(posedge clk);
		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0t ns: %0d results never arrived", $time, expected_results.size());
		end

		$display("Sent %0d strings (%0d bytes): directed forms, faults, quoting, length limit,",
			strings_sent, bytes_sent);
		$display("a long result hold-off and four idle mixes; %0d results compared.",
			results_checked);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/hnvp_pkg.sv
src/http_name_value_parser.sv
verif/tb.sv
